// ===== design/kqm_pkg.sv =====
// Shared operation codes, status codes and cell control type for the keyed queue.
`default_nettype none

package kqm_pkg;

  // Request operation codes.
  localparam logic [1:0] MODE_ENQ = 2'd0;
  localparam logic [1:0] MODE_DEQ = 2'd1;
  localparam logic [1:0] MODE_PRO = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_MISS  = 2'd3;

  // Control broadcast from the top level to every cell.
  typedef struct packed {
    logic enq;    // append at the first empty cell
    logic deq;    // shift everything one cell toward the head
    logic pro;    // promote request in progress
    logic found;  // some valid cell matched the search key
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== design/kqm_cell.sv =====
// One queue cell: holds a key and its valid bit, compares and trades keys with its neighbors.
`default_nettype none

module kqm_cell #(
  parameter int KEY_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire kqm_pkg::cell_ctl_t    ctl,
  input  wire logic [KEY_BITS-1:0]   in_key,
  input  wire logic [KEY_BITS-1:0]   prev_key,
  input  wire logic                  prev_valid,
  input  wire logic [KEY_BITS-1:0]   next_key,
  input  wire logic                  next_valid,
  input  wire logic                  before_in,
  output logic                       before_out,
  output logic [KEY_BITS-1:0]        key_q,
  output logic                       valid_q
);

  import kqm_pkg::*;

  logic match;
  logic is_tail_slot;
  logic shift_in;

  // Compare this cell against the request key and pass the running hit flag along.
  always_comb begin
    match        = valid_q && (key_q == in_key);
    before_out   = before_in | match;
    is_tail_slot = ~valid_q & prev_valid;
    // A cell at or ahead of the first hit (toward the head) takes its neighbor's key on a promote.
    shift_in     = ctl.pro & ctl.found & ~before_in;
  end

  // Valid bit: set by an append, moved toward the head by a dequeue.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (ctl.enq && is_tail_slot) begin
      valid_q <= 1'b1;
    end else if (ctl.deq) begin
      valid_q <= next_valid;
    end
  end

  // Key storage.
  always_ff @(posedge clk) begin
    if (ctl.enq && is_tail_slot) begin
      key_q <= in_key;
    end else if (ctl.deq) begin
      key_q <= next_key;
    end else if (shift_in) begin
      key_q <= prev_key;
    end
  end

endmodule

`default_nettype wire

// ===== design/keyed_queue_move_to_front.sv =====
// Top level of the keyed FIFO queue with move-to-front, built as a row of cells.
`default_nettype none

// Ordered queue of up to DEPTH keys, head in cell 0. Each request (mode, key) is
// enqueue, dequeue or promote, and yields exactly one result (out_key, status,
// occupancy). For each request all cells compare against the key,
// shift or load in parallel, and the result lands in an output register, so a
// new request is taken in every cycle while the result side is not stalled.
// The longest path is the first-match flag that ripples through all DEPTH cells
// on a promote. Mode 3 leaves the queue alone and reports ok.
module keyed_queue_move_to_front #(
  parameter int DEPTH    = 16,
  parameter int KEY_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    mode,
  input  wire logic [KEY_BITS-1:0]           key,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [KEY_BITS-1:0]                out_key,
  output logic [1:0]                         status,
  output logic [$clog2(DEPTH+1)-1:0]         occupancy
);

  import kqm_pkg::*;

  localparam int CW = $clog2(DEPTH+1);

  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic                take;
  logic                full;
  logic                empty;
  logic                found;
  logic [1:0]          status_next;
  cell_ctl_t           ctl;

  logic [KEY_BITS-1:0] cell_key [DEPTH];
  logic [DEPTH-1:0]    cell_valid;
  logic [DEPTH:0]      hit_seen;

  // Input handshake: a new request enters whenever the result register is free.
  assign in_stall = out_valid & out_stall;
  assign take     = in_valid & ~in_stall;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign found = hit_seen[DEPTH];

  // Control broadcast to the cells.
  always_comb begin
    ctl.enq   = take && (mode == MODE_ENQ) && !full;
    ctl.deq   = take && (mode == MODE_DEQ) && !empty;
    ctl.pro   = take && (mode == MODE_PRO);
    ctl.found = found;
  end

  // Row of cells; keys move between neighbors on dequeue and promote.
  assign hit_seen[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_BITS-1:0] prev_key;
    logic                prev_valid;
    logic [KEY_BITS-1:0] next_key;
    logic                next_valid;

    if (i == 0) begin : g_head
      // The head takes the search key itself, which equals the promoted key.
      assign prev_key   = key;
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_key   = cell_key[i-1];
      assign prev_valid = cell_valid[i-1];
    end

    if (i == DEPTH-1) begin : g_last
      assign next_key   = cell_key[i];
      assign next_valid = 1'b0;
    end else begin : g_inner
      assign next_key   = cell_key[i+1];
      assign next_valid = cell_valid[i+1];
    end

    kqm_cell #(
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .in_key     (key),
      .prev_key   (prev_key),
      .prev_valid (prev_valid),
      .next_key   (next_key),
      .next_valid (next_valid),
      .before_in  (hit_seen[i]),
      .before_out (hit_seen[i+1]),
      .key_q      (cell_key[i]),
      .valid_q    (cell_valid[i])
    );
  end

  // Occupancy count and result status.
  always_comb begin
    count_next  = count;
    status_next = ST_OK;
    case (mode)
      MODE_ENQ: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          count_next = count + CW'(1);
        end
      end
      MODE_DEQ: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          count_next = count - CW'(1);
        end
      end
      MODE_PRO: begin
        if (!found) begin
          status_next = ST_MISS;
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (take) begin
      count <= count_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_key   <= ctl.deq ? cell_key[0] : '0;
      status    <= status_next;
      occupancy <= count_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/kqm_check.sv =====
// Port-level checks for the keyed queue, bound to the top level.
`default_nettype none

module kqm_check #(
  parameter int DEPTH    = 16,
  parameter int KEY_BITS = 16
) (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic [1:0]                    mode,
  input wire logic [KEY_BITS-1:0]           key,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [KEY_BITS-1:0]           out_key,
  input wire logic [1:0]                    status,
  input wire logic [$clog2(DEPTH+1)-1:0]    occupancy
);

  import kqm_pkg::*;

  localparam int CW = $clog2(DEPTH+1);

  // Occupancy never exceeds the capacity.
  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (occupancy <= CW'(DEPTH)))
    else $error("occupancy above capacity");

  // A full report only comes from a full queue.
  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FULL) |-> (occupancy == CW'(DEPTH)))
    else $error("full status with room left");

  // An empty report leaves an empty queue and no key.
  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_EMPTY) |-> (occupancy == '0 && out_key == '0))
    else $error("empty status with keys held");

  // A stalled result holds until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_key) && $stable(status)
                                  && $stable(occupancy)))
    else $error("stalled result changed");

  // A stalled request holds until its transfer.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_stall) |=> (in_valid && $stable(mode) && $stable(key)))
    else $error("stalled request changed");

endmodule

bind keyed_queue_move_to_front kqm_check #(
  .DEPTH    (DEPTH),
  .KEY_BITS (KEY_BITS)
) u_kqm_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .mode      (mode),
  .key       (key),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_key   (out_key),
  .status    (status),
  .occupancy (occupancy)
);

`default_nettype wire

// ===== tb/keyed_queue_move_to_front_test.sv =====
// Self-checking testbench for the keyed FIFO queue with move-to-front.
`default_nettype none

module keyed_queue_move_to_front_test;
  import kqm_pkg::*;

  localparam int DEPTH       = 16;
  localparam int KEY_BITS    = 16;
  localparam int OCC_BITS    = $clog2(DEPTH + 1);
  localparam int RANDOM_REQS = 1650;
  localparam int CYCLE_LIMIT = 400000;

  // Mode 3 has no operation behind it; the block leaves the queue alone.
  localparam logic [1:0] MODE_NONE = 2'd3;

  typedef struct {
    logic [1:0]          mode;
    logic [KEY_BITS-1:0] key;
    logic                drain_first;
  } request_t;

  typedef struct {
    logic [KEY_BITS-1:0] key;
    logic [1:0]          status;
    logic [OCC_BITS-1:0] occupancy;
  } response_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          mode = MODE_ENQ;
  logic [KEY_BITS-1:0] key = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [KEY_BITS-1:0] out_key;
  logic [1:0]          status;
  logic [OCC_BITS-1:0] occupancy;

  // Requests waiting to be driven, the shadow queue contents and the pending responses.
  request_t            pending_reqs[$];
  logic [KEY_BITS-1:0] shadow_keys[$];
  response_t           expected_resps[$];

  request_t            next_req;
  response_t           seen_resp;
  logic                req_taken = 1'b0;
  int                  send_gap = 0;
  int                  send_calm = 0;
  int                  stall_left = 0;
  int                  stall_calm = 0;
  int                  cycle_count = 0;
  int                  fail_count = 0;
  int                  reqs_built = 0;
  int                  reqs_sent = 0;
  int                  resps_checked = 0;
  int                  full_hits = 0;
  int                  empty_hits = 0;
  int                  miss_hits = 0;
  int                  moves_done = 0;

  keyed_queue_move_to_front #(
    .DEPTH(DEPTH),
    .KEY_BITS(KEY_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .mode(mode),
    .key(key),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_key(out_key),
    .status(status),
    .occupancy(occupancy)
  );

  always #5 clk = ~clk;

  // Gap length: mostly none or short, a few long, with occasional calm stretches.
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Apply one request to the shadow queue and return the response it must produce.
  function automatic response_t apply_request(logic [1:0] op, logic [KEY_BITS-1:0] k);
    response_t r;
    logic [KEY_BITS-1:0] moved;
    int hit;
    r.key = '0;
    r.status = ST_OK;
    hit = -1;
    case (op)
      MODE_ENQ: begin
        if (shadow_keys.size() >= DEPTH) begin
          r.status = ST_FULL;
          full_hits++;
        end else begin
          shadow_keys.push_back(k);
        end
      end
      MODE_DEQ: begin
        if (shadow_keys.size() == 0) begin
          r.status = ST_EMPTY;
          empty_hits++;
        end else begin
          r.key = shadow_keys.pop_front();
        end
      end
      MODE_PRO: begin
        for (int i = 0; i < shadow_keys.size(); i++) begin
          if (hit < 0 && shadow_keys[i] == k) hit = i;
        end
        if (hit < 0) begin
          r.status = ST_MISS;
          miss_hits++;
        end else if (hit > 0) begin
          moved = shadow_keys[hit];
          shadow_keys.delete(hit);
          shadow_keys.push_front(moved);
          moves_done++;
        end
      end
      default: begin
      end
    endcase
    r.occupancy = OCC_BITS'(shadow_keys.size());
    return r;
  endfunction

  task automatic add_req(logic [1:0] op, logic [KEY_BITS-1:0] k, logic drain);
    request_t q;
    q.mode = op;
    q.key = k;
    q.drain_first = drain;
    pending_reqs.push_back(q);
    reqs_built++;
  endtask

  // Build the directed requests, then phases of random requests with a biased mix.
  task automatic build_stimulus();
    logic [KEY_BITS-1:0] pool[8];
    logic [1:0]          op;
    logic [KEY_BITS-1:0] k;
    int                  bias;
    int                  phase_len;
    int                  counted;
    int                  r;

    // Empty queue corners, then head, middle, tail and missing promotes.
    add_req(MODE_DEQ, 16'h0000, 1'b0);
    add_req(MODE_PRO, 16'h0000, 1'b0);
    add_req(MODE_NONE, 16'hFFFF, 1'b0);
    add_req(MODE_ENQ, 16'h0000, 1'b0);
    add_req(MODE_ENQ, 16'hFFFF, 1'b0);
    add_req(MODE_ENQ, 16'h5A5A, 1'b0);
    add_req(MODE_PRO, 16'hFFFF, 1'b0);
    add_req(MODE_PRO, 16'h5A5A, 1'b0);
    add_req(MODE_PRO, 16'h5A5A, 1'b0);
    add_req(MODE_PRO, 16'h1234, 1'b0);
    // Fill to capacity, then one enqueue too many and a dequeue.
    for (int i = 0; i < DEPTH - 3; i++) add_req(MODE_ENQ, 16'(16'hA5A5 ^ i), 1'b0);
    add_req(MODE_ENQ, 16'hFFFF, 1'b0);
    add_req(MODE_DEQ, 16'h0000, 1'b0);

    counted = 0;
    while (counted < RANDOM_REQS) begin
      // Each phase draws most keys from a small pool so promotes find matches.
      bias = $urandom_range(0, 3);
      phase_len = $urandom_range(20, 80);
      foreach (pool[i]) pool[i] = 16'($urandom_range(0, 65535));
      for (int n = 0; n < phase_len && counted < RANDOM_REQS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          op = MODE_NONE;
        end else begin
          r = $urandom_range(0, 99);
          case (bias)
            0: op = (r < 60) ? MODE_ENQ : (r < 80) ? MODE_DEQ : MODE_PRO;
            1: op = (r < 20) ? MODE_ENQ : (r < 80) ? MODE_DEQ : MODE_PRO;
            2: op = (r < 35) ? MODE_ENQ : (r < 70) ? MODE_DEQ : MODE_PRO;
            default: op = (r < 30) ? MODE_ENQ : (r < 45) ? MODE_DEQ : MODE_PRO;
          endcase
        end
        if ($urandom_range(0, 99) < 85) k = pool[$urandom_range(0, 7)];
        else k = 16'($urandom_range(0, 65535));
        add_req(op, k, ($urandom_range(0, 199) == 0) || (counted == 0));
        if (op != MODE_NONE) counted++;
      end
    end
  endtask

  // Request side: present the next pending request once the last one transferred.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !req_taken) begin
      // Hold the stalled request unchanged.
    end else if (send_gap != 0) begin
      in_valid <= 1'b0;
      send_gap--;
    end else if (pending_reqs.size() != 0 &&
                 !(pending_reqs[0].drain_first && expected_resps.size() != 0)) begin
      next_req = pending_reqs.pop_front();
      in_valid <= 1'b1;
      mode <= next_req.mode;
      key <= next_req.key;
      send_gap = pick_gap(send_calm);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Response side: random stall pattern.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      stall_left = pick_gap(stall_calm);
    end
  end

  // Check each response transfer against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_resps.size() == 0) begin
        $error("response with none expected: out_key %h status %0d occupancy %0d",
               out_key, status, occupancy);
        fail_count++;
      end else begin
        seen_resp = expected_resps.pop_front();
        resps_checked++;
        if (out_key !== seen_resp.key) begin
          $error("out_key: expected %h, got %h", seen_resp.key, out_key);
          fail_count++;
        end
        if (status !== seen_resp.status) begin
          $error("status: expected %0d, got %0d", seen_resp.status, status);
          fail_count++;
        end
        if (occupancy !== seen_resp.occupancy) begin
          $error("occupancy: expected %0d, got %0d", seen_resp.occupancy, occupancy);
          fail_count++;
        end
      end
    end
  end

  // Predict the response of each request transfer.
  always @(posedge clk) begin
    req_taken <= !rst && in_valid && !in_stall;
    if (!rst && in_valid && !in_stall) begin
      expected_resps.push_back(apply_request(mode, key));
      reqs_sent++;
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d responses outstanding",
               cycle_count, expected_resps.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Reset, run all requests, wait for the last response, then report.
  initial begin
    build_stimulus();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    while (reqs_sent != reqs_built || expected_resps.size() != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    $display("Ran %0d requests, %0d responses checked in %0d cycles", reqs_sent,
             resps_checked, cycle_count);
    $display("Saw %0d full, %0d empty, %0d not-found results and %0d moves to the head",
             full_hits, empty_hits, miss_hits, moves_done);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
design/kqm_pkg.sv
design/kqm_cell.sv
design/keyed_queue_move_to_front.sv
design/kqm_check.sv
tb/keyed_queue_move_to_front_test.sv
